FILE: rtl/core/sorted_memo_table_adaptive_bypass_defines.svh
// assertion macros for the sorted memo table block
`ifndef SORTED_MEMO_TABLE_ADAPTIVE_BYPASS_DEFINES_SVH
`define SORTED_MEMO_TABLE_ADAPTIVE_BYPASS_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SMTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smta check failed");

// next-cycle implication, disabled while in reset
`define SMTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smta check failed");

`endif

FILE: rtl/core/smta_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and state type of the sorted memo table
package smta_pkg;
    localparam int KEY_SLOTS_DEF    = 4;
    localparam int ENTRIES_DEF      = 1024;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int ENERGY_W = 48;
    localparam int COUNT_W  = 32;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_MISS     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_UPDATED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_OFF_NOW  = 3'd5;
    localparam logic [2:0] ST_OFF      = 3'd6;
    localparam logic [2:0] ST_CLEARED  = 3'd7;

    localparam logic [1:0] CFG_JUDGE   = 2'd0;
    localparam logic [1:0] CFG_DIVISOR = 2'd1;
    localparam logic [1:0] CFG_CAP     = 2'd2;

    localparam logic [19:0] JUDGE_RST   = 20'd4096;
    localparam logic [9:0]  DIVISOR_RST = 10'd20;
    localparam logic [10:0] CAP_RST     = 11'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_CMP,
        S_SHIFT,
        S_MOVE,
        S_FINISH
    } state_t;
endpackage

FILE: rtl/core/smta_mem.sv
`timescale 1ns / 1ps
// entry memory: one write port, one read port, registered read data
module smta_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 112
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/core/sorted_memo_table_adaptive_bypass.sv
`timescale 1ns / 1ps
// top level of the sorted exact-match memo table with adaptive bypass
//
// usage
// - input channel in_valid/in_ready carries one beat per request: action
//   (lookup, add, clear), key_index, energy and payload
// - output channel out_valid/out_ready returns exactly one beat per request
//   with status, hit, payload_out and the addressed slot's counters
// - cfg_valid/cfg_ready writes judge_after_queries, hit_ratio_divisor and
//   entry_cap by index; cfg_ready is always high, write only while idle
// - one request is worked on at a time; the block takes a new beat while a
//   finished result still sits in the output register
// - lookup: binary search over the n entries held, one memory read per
//   binary-search step
// - add: the search, then for a new key each entry above the sorted position
//   is read and written one place up to open it; clear empties every slot
// - the entry memory has a single read port and a single write port
// - reset empties every slot and restores register defaults; the entry
//   memory is not cleared, only entries below a slot's fill count are read
// - when the receiver stalls, the result holds in the output register and
//   the next request waits in its final step until the register frees
module sorted_memo_table_adaptive_bypass #(
    parameter int KEY_SLOTS    = smta_pkg::KEY_SLOTS_DEF,
    parameter int ENTRIES      = smta_pkg::ENTRIES_DEF,
    parameter int PAYLOAD_BITS = smta_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [1:0]  key_index,
    input  logic [47:0] energy,
    input  logic [63:0] payload,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        hit,
    output logic [63:0] payload_out,
    output logic [10:0] entries_held,
    output logic [31:0] queries_seen,
    output logic [31:0] hits_seen,
    output logic        slot_disabled,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import smta_pkg::*;

    localparam int SW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int PW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = KEY_SLOTS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = ENERGY_W + PAYLOAD_BITS;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               present;
        logic               off;
        logic [COUNT_W-1:0] q;
        logic [COUNT_W-1:0] h;
        logic [PW-1:0]      fill;
    } slot_t;

    // configuration registers
    logic [19:0] judge_reg;
    logic [9:0]  div_reg;
    logic [10:0] cap_reg;

    // per-slot bookkeeping, small enough for flops
    slot_t slots_reg [KEY_SLOTS];

    state_t                  state_reg, state_next;
    logic [1:0]              act_reg, act_next;
    logic                    key_ok_reg, key_ok_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic [ENERGY_W-1:0]     energy_reg, energy_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [AW-1:0]           base_reg, base_next;
    logic [PW-1:0]           lo_reg, lo_next;
    logic [PW-1:0]           hi_reg, hi_next;
    logic [PW-1:0]           mid_reg, mid_next;
    logic [PW-1:0]           idx_reg, idx_next;
    logic                    eq_reg, eq_next;
    logic [PAYLOAD_BITS-1:0] fpay_reg, fpay_next;
    logic [2:0]              res_reg, res_next;
    logic                    rhit_reg, rhit_next;
    logic                    zero_reg, zero_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic        hit_reg, hit_next;
    logic [63:0] pout_reg, pout_next;
    logic [10:0] held_reg, held_next;
    logic [31:0] qs_reg, qs_next;
    logic [31:0] hs_reg, hs_next;
    logic        off_reg, off_next;

    // slot update commands from the sequencer
    logic  slot_we;
    logic  clr_all;
    slot_t slot_new;
    slot_t cur;
    slot_t eff;

    // memory port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata;

    logic [PW-1:0]    cap_eff;
    logic [41:0]      hit_prod;
    logic             judge_fail;
    logic [PW-1:0]    mid_calc;

    smta_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign payload_out   = pout_reg;
    assign entries_held  = held_reg;
    assign queries_seen  = qs_reg;
    assign hits_seen     = hs_reg;
    assign slot_disabled = off_reg;

    // view of the addressed slot, empty when the key is out of range
    always_comb
    begin
        cur = '0;
        if (key_ok_reg)
        begin
            cur = slots_reg[slot_reg];
        end
        // an absent slot gets created fresh by an add
        eff = cur;
        if (!cur.present)
        begin
            eff         = '0;
            eff.present = 1'b1;
        end
    end

    // effective cap is the smaller of the register and the table depth
    assign cap_eff    = (32'(cap_reg) < ENTRIES) ? PW'(cap_reg) : PW'(ENTRIES);
    assign hit_prod   = 42'(eff.h) * 42'(div_reg);
    assign judge_fail = (eff.q >= 32'(judge_reg)) && (hit_prod < 42'(eff.q));
    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_ok_next    = key_ok_reg;
        slot_next      = slot_reg;
        energy_next    = energy_reg;
        pay_next       = pay_reg;
        base_next      = base_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        eq_next        = eq_reg;
        fpay_next      = fpay_reg;
        res_next       = res_reg;
        rhit_next      = rhit_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        pout_next      = pout_reg;
        held_next      = held_reg;
        qs_next        = qs_reg;
        hs_next        = hs_reg;
        off_next       = off_reg;
        slot_we        = 1'b0;
        clr_all        = 1'b0;
        slot_new       = cur;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = base_reg + AW'(lo_reg);
        mem_raddr      = base_reg + AW'(mid_calc);
        mem_wdata      = {energy_reg, pay_reg};

        // output beat leaves when taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    key_ok_next = (32'(key_index) < KEY_SLOTS);
                    slot_next   = (32'(key_index) < KEY_SLOTS) ? SW'(key_index) : '0;
                    energy_next = energy;
                    pay_next    = payload[PAYLOAD_BITS-1:0];
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                base_next = AW'(32'(slot_reg) * ENTRIES);
                lo_next   = '0;
                eq_next   = 1'b0;
                rhit_next = 1'b0;
                res_next  = ST_MISS;
                zero_next = !(key_ok_reg && cur.present);
                case (act_reg)
                    ACT_CLEAR:
                    begin
                        clr_all    = 1'b1;
                        res_next   = ST_CLEARED;
                        zero_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    ACT_LOOKUP:
                    begin
                        if (!key_ok_reg || !cur.present)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (cur.off)
                        begin
                            res_next   = ST_OFF;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            slot_we    = 1'b1;
                            slot_new.q = (cur.q == COUNT_MAX) ? cur.q : cur.q + 1'b1;
                            hi_next    = cur.fill;
                            state_next = S_SEARCH;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (!key_ok_reg)
                        begin
                            res_next   = ST_FULL;
                            zero_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            slot_we   = 1'b1;
                            slot_new  = eff;
                            zero_next = 1'b0;
                            hi_next   = eff.fill;
                            if (eff.off)
                            begin
                                res_next   = ST_OFF;
                                state_next = S_FINISH;
                            end
                            else if (judge_fail)
                            begin
                                // poor hit rate: shut off and drop the entries
                                slot_new.off  = 1'b1;
                                slot_new.fill = '0;
                                res_next      = ST_OFF_NOW;
                                state_next    = S_FINISH;
                            end
                            else if (eff.fill >= cap_eff)
                            begin
                                res_next   = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else if (act_reg == ACT_LOOKUP)
                begin
                    if (eq_reg)
                    begin
                        slot_we    = 1'b1;
                        slot_new.h = (cur.h == COUNT_MAX) ? cur.h : cur.h + 1'b1;
                        res_next   = ST_HIT;
                        rhit_next  = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else if (eq_reg)
                begin
                    mem_we     = 1'b1;
                    res_next   = ST_UPDATED;
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = cur.fill;
                    state_next = S_SHIFT;
                end
            end
            S_CMP:
            begin
                // lower-bound step; eq tracks the entry last taken as upper bound
                if (mem_rdata[MW-1 -: ENERGY_W] < energy_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next   = mid_reg;
                    eq_next   = (mem_rdata[MW-1 -: ENERGY_W] == energy_reg);
                    fpay_next = mem_rdata[PAYLOAD_BITS-1:0];
                end
                state_next = S_SEARCH;
            end
            S_SHIFT:
            begin
                if (idx_reg > lo_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_reg + AW'(idx_reg - 1'b1);
                    state_next = S_MOVE;
                end
                else
                begin
                    mem_we        = 1'b1;
                    slot_we       = 1'b1;
                    slot_new.fill = cur.fill + 1'b1;
                    res_next      = ST_INSERTED;
                    state_next    = S_FINISH;
                end
            end
            S_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = base_reg + AW'(idx_reg);
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHIFT;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    hit_next       = rhit_reg;
                    pout_next      = rhit_reg ? 64'(fpay_reg) : '0;
                    held_next      = zero_reg ? '0 : 11'(cur.fill);
                    qs_next        = zero_reg ? '0 : cur.q;
                    hs_next        = zero_reg ? '0 : cur.h;
                    off_next       = zero_reg ? 1'b0 : cur.off;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            judge_reg     <= JUDGE_RST;
            div_reg       <= DIVISOR_RST;
            cap_reg       <= CAP_RST;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_JUDGE:   judge_reg <= cfg_data;
                    CFG_DIVISOR: div_reg   <= cfg_data[9:0];
                    CFG_CAP:     cap_reg   <= cfg_data[10:0];
                    default:     ;
                endcase
            end
            if (clr_all)
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    slots_reg[i] <= '0;
                end
            end
            else if (slot_we)
            begin
                slots_reg[slot_reg] <= slot_new;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_ok_reg <= key_ok_next;
        slot_reg   <= slot_next;
        energy_reg <= energy_next;
        pay_reg    <= pay_next;
        base_reg   <= base_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        eq_reg     <= eq_next;
        fpay_reg   <= fpay_next;
        res_reg    <= res_next;
        rhit_reg   <= rhit_next;
        zero_reg   <= zero_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        pout_reg   <= pout_next;
        held_reg   <= held_next;
        qs_reg     <= qs_next;
        hs_reg     <= hs_next;
        off_reg    <= off_next;
    end
endmodule

FILE: rtl/core/smta_checker.sv
`timescale 1ns / 1ps
// port-level checks of the sorted memo table, bound to the top level
`include "sorted_memo_table_adaptive_bypass_defines.svh"
module smta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        hit,
    input logic [63:0] payload_out,
    input logic [10:0] entries_held,
    input logic [31:0] queries_seen,
    input logic [31:0] hits_seen,
    input logic        slot_disabled
);
    import smta_pkg::*;

    `SMTA_ASSERT_IMP(a_hit_status, clk, rst_n, out_valid, (hit == (status == ST_HIT)))
    `SMTA_ASSERT_IMP(a_miss_no_pay, clk, rst_n, out_valid && !hit, payload_out == 64'd0)
    `SMTA_ASSERT_IMP(a_clear_zero, clk, rst_n, out_valid && (status == ST_CLEARED),
        (entries_held == 11'd0) && (queries_seen == 32'd0) && !slot_disabled)
    `SMTA_ASSERT_IMP(a_hits_le_queries, clk, rst_n, out_valid, hits_seen <= queries_seen)
    `SMTA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(payload_out))
endmodule

bind sorted_memo_table_adaptive_bypass smta_checker u_smta_checker (.*);
